### rtl/quaternion_small_angle_update_unit_macros.svh
// Assertion macros for the quaternion small angle update unit.
// Used by the port checker; needs clk and rst_n in scope.
`ifndef QUATERNION_SMALL_ANGLE_UPDATE_UNIT_MACROS_SVH
`define QUATERNION_SMALL_ANGLE_UPDATE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define QSAU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qsau assertion failed");

// next-cycle implication, checked outside reset
`define QSAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qsau assertion failed");

`endif

### rtl/qsau_pkg.sv
// Shared constants for the quaternion small angle update unit.
// No dependencies.
package qsau_pkg;

  localparam int MANT_BITS = 30;
  localparam int NUM_W     = 64;
  localparam int LANES     = 9;

endpackage

### rtl/qsau_divider.sv
// Pipelined restoring divider, nine lanes sharing one divisor.
// One quotient bit per stage; depends on qsau_pkg.
module qsau_divider #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic                                ce,
  input  logic [qsau_pkg::NUM_W-1:0]          num_mag [qsau_pkg::LANES],
  input  logic                                num_neg [qsau_pkg::LANES],
  input  logic [qsau_pkg::NUM_W-1:0]          n2,
  output logic [FRAC_BITS+1:0]                quo     [qsau_pkg::LANES],
  output logic                                neg     [qsau_pkg::LANES]
);

  localparam int NW    = qsau_pkg::NUM_W;
  localparam int LN    = qsau_pkg::LANES;
  localparam int QW    = FRAC_BITS + 2;
  localparam int DEPTH = FRAC_BITS + 2;

  logic [NW-1:0] a_r   [DEPTH][LN];
  logic [QW-1:0] q_r   [DEPTH][LN];
  logic          neg_r [DEPTH][LN];
  logic [NW-1:0] d_r   [DEPTH];

  logic [NW-1:0] a0_nxt [LN];
  logic [QW-1:0] q0_nxt [LN];

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      a0_nxt[l] = num_mag[l];
      q0_nxt[l] = '0;
      if (num_mag[l] >= n2) begin
        q0_nxt[l] = QW'(1);
        a0_nxt[l] = num_mag[l] - n2;
      end
      if (a0_nxt[l] >= n2) begin
        a0_nxt[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d_r[0] <= n2;
      for (int l = 0; l < LN; l++) begin
        a_r[0][l]   <= a0_nxt[l];
        q_r[0][l]   <= q0_nxt[l];
        neg_r[0][l] <= num_neg[l];
      end
    end
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_step
    logic [NW-1:0] a_nxt [LN];
    logic [QW-1:0] q_nxt [LN];

    always_comb begin
      for (int l = 0; l < LN; l++) begin
        a_nxt[l] = a_r[k-1][l] << 1;
        q_nxt[l] = q_r[k-1][l] << 1;
        if (a_nxt[l] >= d_r[k-1]) begin
          a_nxt[l] = a_nxt[l] - d_r[k-1];
          q_nxt[l] = q_nxt[l] | QW'(1);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        d_r[k] <= d_r[k-1];
        for (int l = 0; l < LN; l++) begin
          a_r[k][l]   <= a_nxt[l];
          q_r[k][l]   <= q_nxt[l];
          neg_r[k][l] <= neg_r[k-1][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      quo[l] = q_r[DEPTH-1][l];
      neg[l] = neg_r[DEPTH-1][l];
    end
  end

endmodule

### rtl/quaternion_small_angle_update_unit.sv
// Quaternion small angle update: q * (1, u/2), normalized, as a rotation matrix.
// One item per cycle while the output is not stalled; the
// divider pipeline yields one quotient bit per stage. Stalls freeze all stages.
// Synchronous active-low reset clears the valid bits only.
// Depends on qsau_pkg and qsau_divider.
module quaternion_small_angle_update_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_quat_w,
  input  logic signed [DATA_WIDTH-1:0] in_quat_x,
  input  logic signed [DATA_WIDTH-1:0] in_quat_y,
  input  logic signed [DATA_WIDTH-1:0] in_quat_z,
  input  logic signed [DATA_WIDTH-1:0] in_rate_x,
  input  logic signed [DATA_WIDTH-1:0] in_rate_y,
  input  logic signed [DATA_WIDTH-1:0] in_rate_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_m00,
  output logic signed [DATA_WIDTH-1:0] out_m01,
  output logic signed [DATA_WIDTH-1:0] out_m02,
  output logic signed [DATA_WIDTH-1:0] out_m10,
  output logic signed [DATA_WIDTH-1:0] out_m11,
  output logic signed [DATA_WIDTH-1:0] out_m12,
  output logic signed [DATA_WIDTH-1:0] out_m20,
  output logic signed [DATA_WIDTH-1:0] out_m21,
  output logic signed [DATA_WIDTH-1:0] out_m22,
  output logic                         out_degenerate
);

  localparam int DW    = DATA_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int PW    = ((2*DW > DW+F+1) ? 2*DW : DW+F+1) + 2;
  localparam int SW    = $clog2(PW+1);
  localparam int MB    = qsau_pkg::MANT_BITS;
  localparam int NW    = qsau_pkg::NUM_W;
  localparam int LN    = qsau_pkg::LANES;
  localparam int QW    = F + 2;
  localparam int DEPTH = F + 2;
  localparam int LAT   = DEPTH + 7;

  // product indices, stage one
  localparam int P_XX = 0, P_YY = 1, P_ZZ = 2, P_WX = 3, P_YZ = 4, P_ZY = 5;
  localparam int P_WY = 6, P_XZ = 7, P_ZX = 8, P_WZ = 9, P_XY = 10, P_YX = 11;
  // cross product indices, stage five
  localparam int C_XY = 0, C_XZ = 1, C_YZ = 2, C_WX = 3, C_WY = 4, C_WZ = 5;
  // matrix entry lanes
  localparam int E00 = 0, E01 = 1, E02 = 2, E10 = 3, E11 = 4;
  localparam int E12 = 5, E20 = 6, E21 = 7, E22 = 8;

  function automatic logic signed [NW-1:0] apply_sign(input logic [2*MB-1:0] m,
                                                       input logic s);
    logic signed [NW-1:0] v;
    v = signed'(NW'(m));
    return s ? -v : v;
  endfunction

  logic            ce;
  logic [LAT:1]    vld_r;
  logic [LAT:3]    deg_r;

  assign ce       = !vld_r[LAT] || out_ready;
  assign in_ready = ce;
  assign out_valid = vld_r[LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[LAT-1:1], in_valid};
    end
  end

  // stage 1: products
  logic signed [DW-1:0]   quat_r [4];
  logic signed [2*DW-1:0] prod_r [12];

  always_ff @(posedge clk) begin
    if (ce) begin
      quat_r[0]    <= in_quat_w;
      quat_r[1]    <= in_quat_x;
      quat_r[2]    <= in_quat_y;
      quat_r[3]    <= in_quat_z;
      prod_r[P_XX] <= in_quat_x * in_rate_x;
      prod_r[P_YY] <= in_quat_y * in_rate_y;
      prod_r[P_ZZ] <= in_quat_z * in_rate_z;
      prod_r[P_WX] <= in_quat_w * in_rate_x;
      prod_r[P_YZ] <= in_quat_y * in_rate_z;
      prod_r[P_ZY] <= in_quat_z * in_rate_y;
      prod_r[P_WY] <= in_quat_w * in_rate_y;
      prod_r[P_XZ] <= in_quat_x * in_rate_z;
      prod_r[P_ZX] <= in_quat_z * in_rate_x;
      prod_r[P_WZ] <= in_quat_w * in_rate_z;
      prod_r[P_XY] <= in_quat_x * in_rate_y;
      prod_r[P_YX] <= in_quat_y * in_rate_x;
    end
  end

  // stage 2: Hamilton product sums
  logic signed [PW-1:0] p_nxt [4];
  logic signed [PW-1:0] p_r   [4];
  logic signed [PW-1:0] qs    [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qs[i] = PW'(quat_r[i]) <<< (F+1);
    end
    p_nxt[0] = qs[0] - PW'(prod_r[P_XX]) - PW'(prod_r[P_YY]) - PW'(prod_r[P_ZZ]);
    p_nxt[1] = PW'(prod_r[P_WX]) + qs[1] + PW'(prod_r[P_YZ]) - PW'(prod_r[P_ZY]);
    p_nxt[2] = PW'(prod_r[P_WY]) - PW'(prod_r[P_XZ]) + qs[2] + PW'(prod_r[P_ZX]);
    p_nxt[3] = PW'(prod_r[P_WZ]) + PW'(prod_r[P_XY]) - PW'(prod_r[P_YX]) + qs[3];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p_r <= p_nxt;
    end
  end

  // stage 3: magnitudes and normalizing shift
  logic [PW-1:0] mag_nxt [4];
  logic [PW-1:0] mag_r   [4];
  logic          sgn_r   [4];
  logic [PW-1:0] or_mag;
  logic [SW-1:0] sh_nxt;
  logic [SW-1:0] sh_r;

  always_comb begin
    or_mag = '0;
    for (int i = 0; i < 4; i++) begin
      mag_nxt[i] = p_r[i][PW-1] ? PW'(-p_r[i]) : PW'(p_r[i]);
      or_mag     = or_mag | mag_nxt[i];
    end
    sh_nxt = '0;
    for (int i = 0; i < PW; i++) begin
      if (or_mag[i] && i >= MB) begin
        sh_nxt = SW'(i - MB + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 4; i++) begin
        mag_r[i] <= mag_nxt[i];
        sgn_r[i] <= p_r[i][PW-1];
      end
      sh_r     <= sh_nxt;
      deg_r[3] <= (or_mag == '0);
    end
  end

  // stage 4: reduce to mantissa
  logic [MB-1:0] red_r  [4];
  logic          rsgn_r [4];
  logic [PW-1:0] shifted [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      shifted[i] = mag_r[i] >> sh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 4; i++) begin
        red_r[i]  <= shifted[i][MB-1:0];
        rsgn_r[i] <= sgn_r[i];
      end
    end
  end

  // stage 5: squares and cross products
  logic [2*MB-1:0] sq_r [4];
  logic [2*MB-1:0] cp_r [6];
  logic            cs_r [6];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= red_r[i] * red_r[i];
      end
      cp_r[C_XY] <= red_r[1] * red_r[2];
      cp_r[C_XZ] <= red_r[1] * red_r[3];
      cp_r[C_YZ] <= red_r[2] * red_r[3];
      cp_r[C_WX] <= red_r[0] * red_r[1];
      cp_r[C_WY] <= red_r[0] * red_r[2];
      cp_r[C_WZ] <= red_r[0] * red_r[3];
      cs_r[C_XY] <= rsgn_r[1] ^ rsgn_r[2];
      cs_r[C_XZ] <= rsgn_r[1] ^ rsgn_r[3];
      cs_r[C_YZ] <= rsgn_r[2] ^ rsgn_r[3];
      cs_r[C_WX] <= rsgn_r[0] ^ rsgn_r[1];
      cs_r[C_WY] <= rsgn_r[0] ^ rsgn_r[2];
      cs_r[C_WZ] <= rsgn_r[0] ^ rsgn_r[3];
    end
  end

  // stage 6: norm and numerators
  logic signed [NW-1:0] cv  [6];
  logic signed [NW-1:0] sv  [4];
  logic signed [NW-1:0] num [LN];
  logic [NW-1:0]        nmag_nxt [LN];
  logic [NW-1:0]        nmag_r   [LN];
  logic                 nneg_r   [LN];
  logic [NW-1:0]        n2_r;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      cv[i] = apply_sign(cp_r[i], cs_r[i]);
    end
    for (int i = 0; i < 4; i++) begin
      sv[i] = signed'(NW'(sq_r[i]));
    end
    num[E00] = sv[0] + sv[1] - sv[2] - sv[3];
    num[E11] = sv[0] - sv[1] + sv[2] - sv[3];
    num[E22] = sv[0] - sv[1] - sv[2] + sv[3];
    num[E01] = (cv[C_XY] - cv[C_WZ]) <<< 1;
    num[E02] = (cv[C_XZ] + cv[C_WY]) <<< 1;
    num[E10] = (cv[C_XY] + cv[C_WZ]) <<< 1;
    num[E12] = (cv[C_YZ] - cv[C_WX]) <<< 1;
    num[E20] = (cv[C_XZ] - cv[C_WY]) <<< 1;
    num[E21] = (cv[C_YZ] + cv[C_WX]) <<< 1;
    for (int l = 0; l < LN; l++) begin
      nmag_nxt[l] = num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      n2_r <= NW'(sq_r[0]) + NW'(sq_r[1]) + NW'(sq_r[2]) + NW'(sq_r[3]);
      for (int l = 0; l < LN; l++) begin
        nmag_r[l] <= nmag_nxt[l];
        nneg_r[l] <= num[l][NW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      deg_r[LAT:4] <= deg_r[LAT-1:3];
    end
  end

  // divide
  logic [QW-1:0] quo [LN];
  logic          qneg [LN];

  qsau_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .ce      (ce),
    .num_mag (nmag_r),
    .num_neg (nneg_r),
    .n2      (n2_r),
    .quo     (quo),
    .neg     (qneg)
  );

  // round, saturate, sign, identity on zero norm
  localparam logic [QW:0] ONE = (QW+1)'(1) << F;

  logic [QW:0]          rnd   [LN];
  logic signed [DW-1:0] ent   [LN];
  logic signed [DW-1:0] res_r [LN];

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      rnd[l] = ({1'b0, quo[l]} + (QW+1)'(1)) >> 1;
      if (rnd[l] > ONE) begin
        rnd[l] = ONE;
      end
      ent[l] = qneg[l] ? -DW'(rnd[l]) : DW'(rnd[l]);
      if (deg_r[LAT-1]) begin
        ent[l] = (l == E00 || l == E11 || l == E22) ? DW'(ONE) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res_r <= ent;
    end
  end

  assign out_m00        = res_r[E00];
  assign out_m01        = res_r[E01];
  assign out_m02        = res_r[E02];
  assign out_m10        = res_r[E10];
  assign out_m11        = res_r[E11];
  assign out_m12        = res_r[E12];
  assign out_m20        = res_r[E20];
  assign out_m21        = res_r[E21];
  assign out_m22        = res_r[E22];
  assign out_degenerate = deg_r[LAT];

endmodule

### rtl/qsau_chk.sv
// Port checker for the quaternion small angle update unit, bound to the top.
// Depends on quaternion_small_angle_update_unit_macros.svh.
`include "quaternion_small_angle_update_unit_macros.svh"

module qsau_chk #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DATA_WIDTH-1:0] out_m00,
  input logic signed [DATA_WIDTH-1:0] out_m01,
  input logic signed [DATA_WIDTH-1:0] out_m11,
  input logic signed [DATA_WIDTH-1:0] out_m22,
  input logic                         out_degenerate
);

  localparam logic signed [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << FRAC_BITS;

  `QSAU_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_m00) && $stable(out_degenerate))
  `QSAU_ASSERT_NOW(a_ident, out_valid && out_degenerate, out_m00 == ONE && out_m11 == ONE && out_m22 == ONE && out_m01 == 0)
  `QSAU_ASSERT_NOW(a_range, out_valid, out_m01 <= ONE && out_m01 >= -ONE && out_m00 <= ONE && out_m00 >= -ONE)

endmodule

bind quaternion_small_angle_update_unit qsau_chk #(
  .DATA_WIDTH (DATA_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_qsau_chk (.*);
